[rtl/lkvc_pkg.sv]
package lkvc_pkg;

  // Fixed field widths.
  localparam int DATA_BITS = 32;
  localparam int CAP_BITS  = 5;

  // Configuration register indexes and reset values.
  localparam int                  REG_CAPACITY = 0;
  localparam logic [CAP_BITS-1:0] CAP_RESET    = 5'd16;

  // Result value returned by a get that misses.
  localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted word
    logic match;      // register tag compare results
    logic read;       // read the value of the hit entry
    logic touch;      // make the hit entry most recent
    logic write_hit;  // overwrite the value of the hit entry
    logic evict;      // drop the least recent entry
    logic insert;     // place the new key in the lowest free slot
    logic load_out;   // load the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_put;
    logic hit;
    logic need_evict;
    logic out_free;
  } status_t;

endpackage

[rtl/lkvc_ram.sv]
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lkvc_ctrl.sv]
module lkvc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MATCH  = 5'b00010,
    S_ACT    = 5'b00100,
    S_INSERT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one request: compare, act on the entry, insert, hand over.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        if (status.is_put) begin
          if (status.hit) begin
            cmd.write_hit = 1'b1;
            cmd.touch     = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.evict  = status.need_evict;
            state_next = S_INSERT;
          end
        end else begin
          cmd.read   = status.hit;
          cmd.touch  = status.hit;
          state_next = S_DONE;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/lkvc_datapath.sv]
module lkvc_datapath #(
  parameter int NUM_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [lkvc_pkg::CAP_BITS-1:0]          capacity,
  input  logic                                   req_type,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0]  key,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0]  value,
  input  lkvc_pkg::cmd_t                         cmd,
  output lkvc_pkg::status_t                      status,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   hit,
  output logic signed [lkvc_pkg::DATA_BITS-1:0]  read_value
);

  localparam int IDX_BITS = $clog2(NUM_ENTRIES);
  localparam int CNT_BITS = $clog2(NUM_ENTRIES + 1);
  localparam int CMP_BITS = (CNT_BITS > lkvc_pkg::CAP_BITS) ? CNT_BITS : lkvc_pkg::CAP_BITS;

  // Request registers.
  logic                             is_put;
  logic [KEY_BITS-1:0]              key_r;
  logic [lkvc_pkg::DATA_BITS-1:0]   value_r;
  logic signed [63:0]               key_sx;

  // Entry state: valid bits, tags and recency ranks kept per entry.
  logic [NUM_ENTRIES-1:0]           entry_valid;
  logic [KEY_BITS-1:0]              entry_key [NUM_ENTRIES];
  logic [IDX_BITS-1:0]              recency_rank [NUM_ENTRIES];
  logic [CNT_BITS-1:0]              entry_count;

  // Registered compare results.
  logic                             hit_r;
  logic [IDX_BITS-1:0]              hit_idx;
  logic [IDX_BITS-1:0]              hit_rank;

  // Compare and search logic.
  logic [NUM_ENTRIES-1:0]           match_vec;
  logic [IDX_BITS-1:0]              match_idx;
  logic [IDX_BITS-1:0]              match_rank;
  logic [IDX_BITS-1:0]              victim_idx;
  logic [IDX_BITS-1:0]              free_idx;
  logic [CNT_BITS-1:0]              count_m1;
  logic [CMP_BITS-1:0]              cap_ext;
  logic [CMP_BITS-1:0]              eff_cap;

  // Value store.
  logic                             ram_we;
  logic [IDX_BITS-1:0]              ram_waddr;
  logic [lkvc_pkg::DATA_BITS-1:0]   ram_rdata;

  assign key_sx = 64'(key);

  // Tag compare in every entry, and the rank of the matching one.
  always_comb begin
    match_idx  = '0;
    match_rank = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_key[i] == key_r);
      if (match_vec[i]) begin
        match_rank = match_rank | recency_rank[i];
      end
    end
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IDX_BITS'(i);
      end
    end
  end

  // Valid ranks always form 0 .. count-1, so the least recent entry holds count-1.
  assign count_m1 = entry_count - CNT_BITS'(1);

  always_comb begin
    victim_idx = '0;
    free_idx   = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && (recency_rank[i] == count_m1[IDX_BITS-1:0])) begin
        victim_idx = IDX_BITS'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  // Capacity is clamped to the range 1 .. NUM_ENTRIES.
  assign cap_ext = CMP_BITS'(capacity);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(NUM_ENTRIES)) begin
      eff_cap = CMP_BITS'(NUM_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign status.is_put     = is_put;
  assign status.hit        = hit_r;
  assign status.need_evict = (CMP_BITS'(entry_count) >= eff_cap);
  assign status.out_free   = !out_valid || !out_stall;

  // Request and compare registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_put  <= req_type;
      key_r   <= key_sx[KEY_BITS-1:0];
      value_r <= value;
    end
    if (cmd.match) begin
      hit_r    <= |match_vec;
      hit_idx  <= match_idx;
      hit_rank <= match_rank;
    end
  end

  // Valid bits and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
    end else if (cmd.evict) begin
      entry_valid[victim_idx] <= 1'b0;
      entry_count             <= count_m1;
    end else if (cmd.insert) begin
      entry_valid[free_idx] <= 1'b1;
      entry_count           <= entry_count + CNT_BITS'(1);
    end
  end

  // Tags and ranks, updated in place by each entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cmd.touch) begin
        if (IDX_BITS'(i) == hit_idx) begin
          recency_rank[i] <= '0;
        end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
          recency_rank[i] <= recency_rank[i] + IDX_BITS'(1);
        end
      end else if (cmd.insert) begin
        if (IDX_BITS'(i) == free_idx) begin
          entry_key[i]    <= key_r;
          recency_rank[i] <= '0;
        end else if (entry_valid[i]) begin
          recency_rank[i] <= recency_rank[i] + IDX_BITS'(1);
        end
      end
    end
  end

  // Values live in a RAM: written on put, read on a get that hits.
  assign ram_we    = cmd.write_hit || cmd.insert;
  assign ram_waddr = cmd.insert ? free_idx : hit_idx;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::DATA_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .re    (cmd.read),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // Output register holds the result word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit <= hit_r;
      if (is_put) begin
        read_value <= '0;
      end else if (hit_r) begin
        read_value <= ram_rdata;
      end else begin
        read_value <= lkvc_pkg::MISS_VALUE;
      end
    end
  end

endmodule

[rtl/lru_key_value_cache_top.sv]
// Fully associative key-value cache with least-recently-used replacement.
// Each input word is a get (req_type 0) or a put (req_type 1) and yields one
// result word: hit tells whether the key was present, read_value carries the
// stored value on a get hit, -1 on a get miss and 0 on any put. The block
// works on one request at a time. The controller runs the tag compare, then
// a step that reads or writes the hit entry's value and makes it most recent,
// or that evicts the least recent entry at capacity; a put of a new key is then
// inserted, and the result is handed over. The value RAM has a write and a read
// port. A result waits in the output register while the next word is taken.
// The capacity register (address 0) limits the entries in use; 0 acts as 1 and
// values above NUM_ENTRIES act as NUM_ENTRIES. Reset empties the cache at once.
module lru_key_value_cache_top #(
  parameter int NUM_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Request channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0]  key,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0]  value,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   hit,
  output logic signed [lkvc_pkg::DATA_BITS-1:0]  read_value,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [lkvc_pkg::CAP_BITS-1:0] capacity;
  logic                          reg_sel;
  lkvc_pkg::cmd_t                cmd;
  lkvc_pkg::status_t             status;

  // Register decode on the word address.
  assign reg_sel = (paddr[2] == 1'(lkvc_pkg::REG_CAPACITY));
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[lkvc_pkg::CAP_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(capacity) : '0;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .req_type   (req_type),
    .key        (key),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule

[rtl/lkvc_checker.sv]
module lkvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        req_type,
  input logic [31:0] key,
  input logic [31:0] value,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [31:0] read_value,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
    else $error("result word changed while stalled");

  // A miss reports either the get-miss marker or the put result of zero.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (read_value == 32'hFFFF_FFFF) || (read_value == 32'h0))
    else $error("miss result carries an unexpected value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
